FILE: rtl/core/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg: shared types and constants of the PTP timestamp match table
// Entry layout, broadcast control to the cells, codes and reset values.
// ----------------------------------------------------------------------------
package ptm_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic [6:0] MAX_ENTRIES_RST    = 7'd60;
	localparam logic [6:0] WARN_THRESHOLD_RST = 7'd50;
	localparam logic [7:0] AGE_TIMEOUT_RST    = 8'd1;

	typedef enum logic [1:0] {
		ACT_PUSH_MSG = 2'd0,
		ACT_PUSH_TS  = 2'd1,
		ACT_POP      = 2'd2,
		ACT_TICK     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_SPACE  = 2'd1,
		STS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_MAX_ENTRIES    = 2'd0,
		REG_WARN_THRESHOLD = 2'd1,
		REG_AGE_TIMEOUT    = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_MATCH = 2'd1,
		FSM_APPLY = 2'd2,
		FSM_DONE  = 2'd3
	} fsm_t;

	// What every cell does in a cycle
	typedef enum logic [2:0] {
		PH_NONE  = 3'd0,
		PH_AGE   = 3'd1,
		PH_LOAD  = 3'd2,
		PH_STAMP = 3'd3,
		PH_SHIFT = 3'd4
	} phase_t;

	// Which compare drives a cell's hit output
	typedef enum logic [1:0] {
		CMP_KEY = 2'd0,
		CMP_REF = 2'd1,
		CMP_AGE = 2'd2
	} cmp_t;

	typedef struct packed {
		logic        used;
		logic [40:0] key;   // is_ingress, msg_type, ptp_port, sequence_id
		logic [15:0] ref_num;
		logic        bound;
		logic [31:0] sec;
		logic [29:0] nsec;
		logic [7:0]  age;
	} entry_t;

	typedef struct packed {
		phase_t      phase;
		cmp_t        cmp;
		logic [40:0] key;
		logic [15:0] ref_num;
		logic [31:0] sec;
		logic [29:0] nsec;
		logic [7:0]  age;
	} bcast_t;

endpackage

FILE: rtl/core/ptp_timestamp_match_table.sv
// ----------------------------------------------------------------------------
// ptp_timestamp_match_table: pending PTP message table with stamp pairing
// Row of slot cells kept oldest first, sequenced by a small controller.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// with done high for exactly one cycle and must be captured then, as it is
// never held back. push_msg, push_ts and pop go from the accepting edge to
// done through compare all slots, apply and present, and a new command may
// be started in the done cycle. tick goes the same way but stays in apply
// while expired entries remain, since they are squeezed out one per cycle by
// shifting the younger slots down the cell row. Configuration writes are
// always ready and should be issued only while the table is idle.
module ptp_timestamp_match_table #(
	parameter int TABLE_DEPTH = ptm_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic        is_ingress,
	input  logic [15:0] ref_number,
	input  logic [7:0]  msg_type,
	input  logic [15:0] ptp_port,
	input  logic [15:0] sequence_id,
	input  logic [31:0] stamp_seconds,
	input  logic [29:0] stamp_nanoseconds,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_seconds,
	output logic [29:0] found_nanoseconds,
	output logic        stamp_was_bound,
	output logic [6:0]  entry_count,
	output logic        over_warning,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;

	ptm_pkg::fsm_t    state_q, state_d;
	ptm_pkg::action_t act_q;
	ptm_pkg::bcast_t  bc;
	logic [40:0]      key_q;
	logic [15:0]      ref_q;
	logic [31:0]      sec_q;
	logic [29:0]      nsec_q;

	logic [6:0] max_entries_q, warn_threshold_q;
	logic [7:0] age_timeout_q;

	logic [CW-1:0] count_q, count_d;
	logic          warn_q, warn_d;

	logic [TABLE_DEPTH-1:0] hits, match_q, match_d;
	logic [TABLE_DEPTH-1:0] older_hit, first, shift_v, sel_v, load_sel;
	ptm_pkg::entry_t        ents [TABLE_DEPTH];
	ptm_pkg::entry_t        nbrs [TABLE_DEPTH];

	logic        res_load;
	logic [1:0]  res_status;
	logic        res_bound;
	logic [31:0] res_sec;
	logic [29:0] res_nsec;
	logic [31:0] mux_sec;
	logic [29:0] mux_nsec;
	logic        mux_bound;
	logic        any_match, full;

	logic [1:0]  status_q;
	logic [31:0] sec_out_q;
	logic [29:0] nsec_out_q;
	logic        bound_out_q;

	// Cell row
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign nbrs[i] = '0;
		end else begin : g_mid
			assign nbrs[i] = ents[i+1];
		end
		assign load_sel[i] = (CW'(i) == count_q);

		ptm_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.bc    (bc),
			.sel   (sel_v[i]),
			.shift (shift_v[i]),
			.nbr   (nbrs[i]),
			.entry (ents[i]),
			.hit   (hits[i])
		);
	end

	// Locate the oldest matching slot and the slots behind it
	always_comb begin
		older_hit[0] = 1'b0;
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			older_hit[i] = older_hit[i-1] | match_q[i-1];
		end
		first     = match_q & ~older_hit;
		shift_v   = match_q | older_hit;
		any_match = |match_q;
	end

	// Pick the stamp of the oldest match
	always_comb begin
		mux_sec   = '0;
		mux_nsec  = '0;
		mux_bound = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			mux_sec   = mux_sec | ({32{first[i]}} & ents[i].sec);
			mux_nsec  = mux_nsec | ({30{first[i]}} & ents[i].nsec);
			mux_bound = mux_bound | (first[i] & ents[i].bound);
		end
	end

	assign full = (CMPW'(count_q) >= CMPW'(max_entries_q)) ||
		(count_q >= CW'(TABLE_DEPTH));

	// Next state and cell control
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		warn_d     = warn_q;
		match_d    = match_q;
		sel_v      = first;
		res_load   = 1'b0;
		res_status = ptm_pkg::STS_OK;
		res_bound  = 1'b0;
		res_sec    = '0;
		res_nsec   = '0;
		bc.phase   = ptm_pkg::PH_NONE;
		bc.cmp     = ptm_pkg::CMP_KEY;
		bc.key     = key_q;
		bc.ref_num = ref_q;
		bc.sec     = sec_q;
		bc.nsec    = nsec_q;
		bc.age     = age_timeout_q;

		unique case (act_q)
			ptm_pkg::ACT_PUSH_TS: bc.cmp = ptm_pkg::CMP_REF;
			ptm_pkg::ACT_TICK:    bc.cmp = ptm_pkg::CMP_AGE;
			default:              bc.cmp = ptm_pkg::CMP_KEY;
		endcase

		unique case (state_q)
			ptm_pkg::FSM_IDLE, ptm_pkg::FSM_DONE: begin
				if (start) begin
					state_d = ptm_pkg::FSM_MATCH;
				end else begin
					state_d = ptm_pkg::FSM_IDLE;
				end
			end
			ptm_pkg::FSM_MATCH: begin
				// capture hits; tick ages survivors at the same edge
				match_d = hits;
				if (act_q == ptm_pkg::ACT_TICK) begin
					bc.phase = ptm_pkg::PH_AGE;
				end
				state_d = ptm_pkg::FSM_APPLY;
			end
			ptm_pkg::FSM_APPLY: begin
				res_load = 1'b1;
				state_d  = ptm_pkg::FSM_DONE;
				unique case (act_q)
					ptm_pkg::ACT_PUSH_MSG: begin
						if (full) begin
							res_status = ptm_pkg::STS_NO_SPACE;
						end else begin
							bc.phase = ptm_pkg::PH_LOAD;
							sel_v    = load_sel;
							count_d  = count_q + CW'(1);
							if (CMPW'(count_d) > CMPW'(warn_threshold_q)) begin
								warn_d = 1'b1;
							end
						end
					end
					ptm_pkg::ACT_PUSH_TS: begin
						if (any_match) begin
							bc.phase = ptm_pkg::PH_STAMP;
						end else begin
							res_status = ptm_pkg::STS_NOT_FOUND;
						end
					end
					ptm_pkg::ACT_POP: begin
						if (any_match) begin
							bc.phase  = ptm_pkg::PH_SHIFT;
							count_d   = count_q - CW'(1);
							res_bound = mux_bound;
							res_sec   = mux_bound ? mux_sec : 32'd0;
							res_nsec  = mux_bound ? mux_nsec : 30'd0;
							if (CMPW'(count_d) <= CMPW'(warn_threshold_q >> 2)) begin
								warn_d = 1'b0;
							end
						end else begin
							res_status = ptm_pkg::STS_NOT_FOUND;
						end
					end
					ptm_pkg::ACT_TICK: begin
						// squeeze out one expired entry per cycle
						if (any_match) begin
							bc.phase = ptm_pkg::PH_SHIFT;
							count_d  = count_q - CW'(1);
							match_d  = {1'b0, match_q[TABLE_DEPTH-1:1]} & shift_v |
								match_q & ~shift_v;
							res_load = 1'b0;
							state_d  = ptm_pkg::FSM_APPLY;
						end
					end
					default: begin
					end
				endcase
			end
			default: state_d = ptm_pkg::FSM_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptm_pkg::FSM_IDLE;
			count_q <= '0;
			warn_q  <= 1'b0;
			match_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			warn_q  <= warn_d;
			match_q <= match_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q    <= ptm_pkg::MAX_ENTRIES_RST;
			warn_threshold_q <= ptm_pkg::WARN_THRESHOLD_RST;
			age_timeout_q    <= ptm_pkg::AGE_TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ptm_pkg::REG_MAX_ENTRIES:    max_entries_q <= cfg_data[6:0];
				ptm_pkg::REG_WARN_THRESHOLD: warn_threshold_q <= cfg_data[6:0];
				ptm_pkg::REG_AGE_TIMEOUT:    age_timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Latch the command on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ptm_pkg::ACT_PUSH_MSG;
		end else if (start && !busy) begin
			act_q <= ptm_pkg::action_t'(action);
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_q  <= {is_ingress, msg_type, ptp_port, sequence_id};
			ref_q  <= ref_number;
			sec_q  <= stamp_seconds;
			nsec_q <= stamp_nanoseconds;
		end
	end

	// Result registers, loaded in apply and held until the next result
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q    <= res_status;
			sec_out_q   <= res_sec;
			nsec_out_q  <= res_nsec;
			bound_out_q <= res_bound;
		end
	end

	assign busy              = (state_q == ptm_pkg::FSM_MATCH) ||
		(state_q == ptm_pkg::FSM_APPLY);
	assign done              = (state_q == ptm_pkg::FSM_DONE);
	assign cfg_ready         = 1'b1;
	assign status            = status_q;
	assign found_seconds     = sec_out_q;
	assign found_nanoseconds = nsec_out_q;
	assign stamp_was_bound   = bound_out_q;
	assign entry_count       = 7'(count_q);
	assign over_warning      = warn_q;

endmodule

FILE: rtl/core/ptm_cell.sv
// ----------------------------------------------------------------------------
// ptm_cell: one table slot
// Holds one pending message, compares it against the broadcast command and
// takes its younger neighbor's contents when the table closes a gap.
// ----------------------------------------------------------------------------
module ptm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ptm_pkg::bcast_t bc,
	input  logic            sel,
	input  logic            shift,
	input  ptm_pkg::entry_t nbr,
	output ptm_pkg::entry_t entry,
	output logic            hit
);

	logic        used_q;
	logic [40:0] key_q;
	logic [15:0] ref_q;
	logic        bound_q;
	logic [31:0] sec_q;
	logic [29:0] nsec_q;
	logic [7:0]  age_q;

	assign entry = '{used: used_q, key: key_q, ref_num: ref_q, bound: bound_q,
		sec: sec_q, nsec: nsec_q, age: age_q};

	// Compare this slot against the command
	always_comb begin
		unique case (bc.cmp)
			ptm_pkg::CMP_KEY: hit = used_q && (key_q == bc.key);
			ptm_pkg::CMP_REF: hit = used_q && (ref_q == bc.ref_num);
			ptm_pkg::CMP_AGE: hit = used_q && (age_q == 8'd0);
			default:          hit = 1'b0;
		endcase
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (bc.phase == ptm_pkg::PH_LOAD && sel) begin
			used_q <= 1'b1;
		end else if (bc.phase == ptm_pkg::PH_SHIFT && shift) begin
			used_q <= nbr.used;
		end
	end

	// Payload: load, bind stamp, age, or take the neighbor
	always_ff @(posedge clk) begin
		unique case (bc.phase)
			ptm_pkg::PH_LOAD: begin
				if (sel) begin
					key_q   <= bc.key;
					ref_q   <= bc.ref_num;
					bound_q <= 1'b0;
					age_q   <= bc.age;
				end
			end
			ptm_pkg::PH_STAMP: begin
				if (sel) begin
					bound_q <= 1'b1;
					sec_q   <= bc.sec;
					nsec_q  <= bc.nsec;
				end
			end
			ptm_pkg::PH_AGE: begin
				if (used_q && age_q != 8'd0) begin
					age_q <= age_q - 8'd1;
				end
			end
			ptm_pkg::PH_SHIFT: begin
				if (shift) begin
					key_q   <= nbr.key;
					ref_q   <= nbr.ref_num;
					bound_q <= nbr.bound;
					sec_q   <= nbr.sec;
					nsec_q  <= nbr.nsec;
					age_q   <= nbr.age;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
